// ===== rtl/tdhb_pkg.sv =====
package tdhb_pkg;

  localparam int COORD_W = 32;
  localparam int CNT_W   = 32;
  localparam int PPM_W   = 20;
  localparam int BIN_W   = 8;
  localparam int PROD_W  = CNT_W + PPM_W;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

  localparam logic signed [COORD_W-1:0] X_LOW_RESET  = 32'sd2621440;
  localparam logic signed [COORD_W-1:0] X_HIGH_RESET = 32'sd6553600;
  localparam logic signed [COORD_W-1:0] Y_LOW_RESET  = 32'sd0;
  localparam logic signed [COORD_W-1:0] Y_HIGH_RESET = 32'sd52429;
  localparam logic [PPM_W-1:0]          THRESHOLD_RESET = 20'd500;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [PPM_W-1:0] PPM_SCALE = 20'd1000000;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] x_value;
    logic signed [COORD_W-1:0] y_value;
    logic [BIN_W-1:0]          read_row;
    logic [BIN_W-1:0]          read_col;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic [BIN_W-1:0] bin_row;
    logic [BIN_W-1:0] bin_col;
    logic [CNT_W-1:0] cell_count;
    logic [CNT_W-1:0] total_count;
    logic             above_threshold;
  } res_t;

endpackage

// ===== rtl/tdhb_ram.sv =====
module tdhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tdhb_divider.sv =====
module tdhb_divider #(
  parameter int NUM_W = 40,
  parameter int QUO_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_W-1:0]            dividend,
  input  logic [tdhb_pkg::COORD_W-1:0] divisor,
  output logic                        done,
  output logic [QUO_W-1:0]            quotient
);

  // The quotient is known to fit QUO_W bits, so only QUO_W restoring steps run.
  localparam int STEP_W = $clog2(QUO_W);

  logic [NUM_W-1:0]             rem;
  logic [tdhb_pkg::COORD_W-1:0] den;
  logic [STEP_W-1:0]            step;
  logic                         running;
  logic [NUM_W-1:0]             trial;

  assign trial = NUM_W'(den) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        den      <= divisor;
        step     <= STEP_W'(QUO_W - 1);
        quotient <= '0;
        running  <= 1'b1;
      end else if (running) begin
        if (rem >= trial) begin
          rem            <= rem - trial;
          quotient[step] <= 1'b1;
        end
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/two_d_histogram_binner.sv =====
// Two-dimensional histogram of signed Q16.16 (x, y) samples over a BINS by BINS grid.
// An item is taken when start is high and busy is low; its single result is
// shown for exactly one cycle with done high and must be captured then, since
// the receiver cannot hold it off. An add is binned by one shared restoring divider
// that computes the row bin and then the column bin one quotient bit per cycle;
// an axis whose span is zero skips its division. After reset the block clears
// its BINS*BINS count memory one cell per cycle and holds busy high meanwhile;
// configuration writes are taken at any time and belong only to idle periods.
module two_d_histogram_binner #(
  parameter int BINS = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  tdhb_pkg::req_t                       request,
  output logic                                 done,
  output tdhb_pkg::res_t                       result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tdhb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdhb_pkg::COORD_W-1:0]         cfg_data
);

  localparam int DEPTH = BINS * BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BINS + 1);
  localparam int NW    = tdhb_pkg::COORD_W + BW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_ADDR  = 4'd5;
  localparam logic [3:0] S_READ  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_MUL1  = 4'd8;
  localparam logic [3:0] S_MUL2  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]                               state;
  tdhb_pkg::req_t                           req;
  logic signed [tdhb_pkg::COORD_W-1:0]      x_low, x_high, y_low, y_high;
  logic [tdhb_pkg::PPM_W-1:0]               threshold;
  logic [tdhb_pkg::BIN_W-1:0]               row, col;
  logic                                     acc;
  logic                                     axis;
  logic [AW-1:0]                            addr;
  logic [tdhb_pkg::CNT_W-1:0]               cell_cnt, total;
  logic [tdhb_pkg::PROD_W-1:0]              prod_a, prod_b;

  logic                                     x_in, y_in;
  logic                                     read_ok;
  logic signed [tdhb_pkg::COORD_W-1:0]      lo, hi, v;
  logic [tdhb_pkg::COORD_W:0]               span_w, diff_w;
  logic [tdhb_pkg::COORD_W-1:0]             span, diff;
  logic [tdhb_pkg::BIN_W-1:0]               bin;
  logic                                     div_start, div_done;
  logic [NW-1:0]                            div_num;
  logic [BW-1:0]                            div_quot;
  logic [tdhb_pkg::CNT_W-1:0]               rd_data, cell_inc, wr_data;
  logic                                     wr_en;
  logic [tdhb_pkg::CNT_W-1:0]               mul_a;
  logic [tdhb_pkg::PPM_W-1:0]               mul_b;
  logic [tdhb_pkg::PROD_W-1:0]              mul_p;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign x_in = (x_low <= x_high) && (req.x_value >= x_low) && (req.x_value <= x_high);
  assign y_in = (y_low <= y_high) && (req.y_value >= y_low) && (req.y_value <= y_high);
  assign read_ok = (32'(req.read_row) < BINS) && (32'(req.read_col) < BINS);

  assign lo = axis ? y_low : x_low;
  assign hi = axis ? y_high : x_high;
  assign v  = axis ? req.y_value : req.x_value;
  assign span_w  = {hi[tdhb_pkg::COORD_W-1], hi} - {lo[tdhb_pkg::COORD_W-1], lo};
  assign diff_w  = {v[tdhb_pkg::COORD_W-1], v} - {lo[tdhb_pkg::COORD_W-1], lo};
  assign span    = span_w[tdhb_pkg::COORD_W-1:0];
  assign diff    = diff_w[tdhb_pkg::COORD_W-1:0];
  assign div_num = NW'(diff) * NW'(BINS);
  assign div_start = (state == S_PREP) && (span != '0);

  assign bin = (32'(div_quot) >= BINS) ? tdhb_pkg::BIN_W'(BINS - 1)
                                       : tdhb_pkg::BIN_W'(div_quot);

  assign cell_inc = (rd_data == tdhb_pkg::CNT_MAX) ? rd_data : rd_data + 1'b1;
  assign wr_en    = (state == S_CLEAR) || ((state == S_UPD) && acc);
  assign wr_data  = (state == S_CLEAR) ? '0 : cell_inc;

  assign mul_a = (state == S_MUL1) ? cell_cnt : total;
  assign mul_b = (state == S_MUL1) ? tdhb_pkg::PPM_SCALE : threshold;
  assign mul_p = tdhb_pkg::PROD_W'(mul_a) * tdhb_pkg::PROD_W'(mul_b);

  tdhb_divider #(
    .NUM_W (NW),
    .QUO_W (BW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quot)
  );

  tdhb_ram #(
    .WIDTH (tdhb_pkg::CNT_W),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low     <= tdhb_pkg::X_LOW_RESET;
      x_high    <= tdhb_pkg::X_HIGH_RESET;
      y_low     <= tdhb_pkg::Y_LOW_RESET;
      y_high    <= tdhb_pkg::Y_HIGH_RESET;
      threshold <= tdhb_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tdhb_pkg::CFG_X_LOW:     x_low     <= cfg_data;
        tdhb_pkg::CFG_X_HIGH:    x_high    <= cfg_data;
        tdhb_pkg::CFG_Y_LOW:     y_low     <= cfg_data;
        tdhb_pkg::CFG_Y_HIGH:    y_high    <= cfg_data;
        tdhb_pkg::CFG_THRESHOLD: threshold <= cfg_data[tdhb_pkg::PPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr  <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            req   <= request;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (req.operation == tdhb_pkg::OP_READ) begin
            row      <= req.read_row;
            col      <= req.read_col;
            acc      <= 1'b0;
            cell_cnt <= '0;
            state    <= read_ok ? S_ADDR : S_MUL1;
          end else if (x_in && y_in) begin
            acc   <= 1'b1;
            axis  <= 1'b0;
            state <= S_PREP;
          end else begin
            row      <= '0;
            col      <= '0;
            acc      <= 1'b0;
            cell_cnt <= '0;
            state    <= S_MUL1;
          end
        end
        S_PREP: begin
          if (span != '0) begin
            state <= S_DIV;
          end else if (!axis) begin
            row  <= '0;
            axis <= 1'b1;
          end else begin
            col   <= '0;
            state <= S_ADDR;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!axis) begin
              row   <= bin;
              axis  <= 1'b1;
              state <= S_PREP;
            end else begin
              col   <= bin;
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          addr  <= AW'(32'(row) * BINS + 32'(col));
          state <= S_READ;
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (acc) begin
            cell_cnt <= cell_inc;
            if (total != tdhb_pkg::CNT_MAX) begin
              total <= total + 1'b1;
            end
          end else begin
            cell_cnt <= rd_data;
          end
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod_a <= mul_p;
          state  <= S_MUL2;
        end
        S_MUL2: begin
          prod_b <= mul_p;
          state  <= S_FIN;
        end
        S_FIN: begin
          result.accepted        <= acc;
          result.bin_row         <= row;
          result.bin_col         <= col;
          result.cell_count      <= cell_cnt;
          result.total_count     <= total;
          result.above_threshold <= (prod_a > prod_b);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/two_d_histogram_binner_tb.sv =====
module two_d_histogram_binner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS = 100;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    tdhb_pkg::req_t rq;
    bit             typed;
    tdhb_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tdhb_pkg::req_t request = '0;
  logic done;
  tdhb_pkg::res_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tdhb_pkg::CFG_IDX_W-1:0] cfg_index = tdhb_pkg::CFG_X_LOW;
  logic [tdhb_pkg::COORD_W-1:0] cfg_data = '0;

  logic signed [tdhb_pkg::COORD_W-1:0] lim_x_lo = tdhb_pkg::X_LOW_RESET;
  logic signed [tdhb_pkg::COORD_W-1:0] lim_x_hi = tdhb_pkg::X_HIGH_RESET;
  logic signed [tdhb_pkg::COORD_W-1:0] lim_y_lo = tdhb_pkg::Y_LOW_RESET;
  logic signed [tdhb_pkg::COORD_W-1:0] lim_y_hi = tdhb_pkg::Y_HIGH_RESET;
  logic [tdhb_pkg::PPM_W-1:0] thresh_ppm = tdhb_pkg::THRESHOLD_RESET;
  logic [tdhb_pkg::CNT_W-1:0] hist [BINS*BINS];
  logic [tdhb_pkg::CNT_W-1:0] total_hits = '0;

  tdhb_pkg::res_t pending_results[$];
  stim_row_t directed_rows[$];
  int fail_count = 0;
  int quiet_cycles = 0;

  logic signed [tdhb_pkg::COORD_W-1:0] last_x, last_y;
  logic [tdhb_pkg::BIN_W-1:0] last_row = '0;
  logic [tdhb_pkg::BIN_W-1:0] last_col = '0;
  bit have_last = 0;

  two_d_histogram_binner #(.BINS(BINS)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic bit axis_bin(input logic signed [tdhb_pkg::COORD_W-1:0] v, lo, hi,
                                  output logic [tdhb_pkg::BIN_W-1:0] bin);
    longint span;
    longint offset;
    longint q;
    bin = '0;
    if (lo > hi || v < lo || v > hi) return 1'b0;
    span = longint'(hi) - longint'(lo);
    offset = longint'(v) - longint'(lo);
    if (span == 0) return 1'b1;
    q = offset * BINS / span;
    if (q >= BINS) q = BINS - 1;
    bin = q[tdhb_pkg::BIN_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic over_threshold(logic [tdhb_pkg::CNT_W-1:0] cell_cnt,
                                          logic [tdhb_pkg::CNT_W-1:0] total);
    longint unsigned lhs;
    longint unsigned rhs;
    lhs = longint'(cell_cnt) * 64'd1000000;
    rhs = longint'(total) * longint'(thresh_ppm);
    return lhs > rhs;
  endfunction

  function automatic tdhb_pkg::res_t predict_histogram(tdhb_pkg::req_t rq);
    tdhb_pkg::res_t o;
    logic [tdhb_pkg::BIN_W-1:0] r, c;
    bit ok_x, ok_y;
    int idx;
    o = '0;
    o.total_count = total_hits;
    if (rq.operation == tdhb_pkg::OP_ADD) begin
      ok_x = axis_bin(rq.x_value, lim_x_lo, lim_x_hi, r);
      ok_y = axis_bin(rq.y_value, lim_y_lo, lim_y_hi, c);
      if (ok_x && ok_y) begin
        idx = int'(r) * BINS + int'(c);
        if (hist[idx] != tdhb_pkg::CNT_MAX) hist[idx] = hist[idx] + 1;
        if (total_hits != tdhb_pkg::CNT_MAX) total_hits = total_hits + 1;
        o = '{1'b1, r, c, hist[idx], total_hits, over_threshold(hist[idx], total_hits)};
      end
    end else begin
      o.bin_row = rq.read_row;
      o.bin_col = rq.read_col;
      if (rq.read_row < BINS && rq.read_col < BINS) begin
        idx = int'(rq.read_row) * BINS + int'(rq.read_col);
        o.cell_count = hist[idx];
        o.above_threshold = over_threshold(hist[idx], total_hits);
      end
    end
    return o;
  endfunction

  function automatic logic signed [tdhb_pkg::COORD_W-1:0] pick_coord(
      logic signed [tdhb_pkg::COORD_W-1:0] lo, hi);
    longint unsigned draw;
    longint width;
    logic signed [tdhb_pkg::COORD_W-1:0] pick;
    width = longint'(hi) - longint'(lo) + 1;
    draw = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: pick = lo;
      1: pick = hi;
      2: pick = lo - 1;
      3: pick = hi + 1;
      4: pick = $urandom();
      default: begin
        if (width > 0) pick = 32'(longint'(lo) + longint'(draw % width));
        else pick = $urandom();
      end
    endcase
    return pick;
  endfunction

  function automatic tdhb_pkg::req_t random_request();
    tdhb_pkg::req_t rq;
    rq.x_value = $urandom();
    rq.y_value = $urandom();
    rq.read_row = $urandom_range(0, 255);
    rq.read_col = $urandom_range(0, 255);
    if ($urandom_range(0, 9) < 7) begin
      rq.operation = tdhb_pkg::OP_ADD;
      if (have_last && $urandom_range(0, 3) == 0) begin
        rq.x_value = last_x;
        rq.y_value = last_y;
      end else begin
        rq.x_value = pick_coord(lim_x_lo, lim_x_hi);
        rq.y_value = pick_coord(lim_y_lo, lim_y_hi);
      end
    end else begin
      rq.operation = tdhb_pkg::OP_READ;
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          rq.read_row = last_row;
          rq.read_col = last_col;
        end
        3, 4: begin
          rq.read_row = $urandom_range(0, BINS - 1);
          rq.read_col = $urandom_range(0, BINS - 1);
        end
        default: ;
      endcase
    end
    return rq;
  endfunction

  function automatic void dir_row(logic op, logic signed [tdhb_pkg::COORD_W-1:0] x, y,
                                  logic [tdhb_pkg::BIN_W-1:0] row, col, bit typed,
                                  tdhb_pkg::res_t want);
    stim_row_t s;
    s.rq = '{op, x, y, row, col};
    s.typed = typed;
    s.want = want;
    directed_rows = {directed_rows, s};
  endfunction

  // Start stays high after acceptance so back-to-back items need no extra step.
  task automatic send_item(tdhb_pkg::req_t rq, bit typed, tdhb_pkg::res_t typed_want);
    tdhb_pkg::res_t want;
    request <= rq;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    want = predict_histogram(rq);
    if (typed) want = typed_want;
    pending_results = {pending_results, want};
    if (want.accepted) begin
      last_x = rq.x_value;
      last_y = rq.y_value;
      last_row = want.bin_row;
      last_col = want.bin_col;
      have_last = 1;
    end
  endtask

  task automatic idle_before_item(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tdhb_pkg::CFG_IDX_W-1:0] idx,
                           logic [tdhb_pkg::COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tdhb_pkg::CFG_X_LOW:     lim_x_lo = data;
      tdhb_pkg::CFG_X_HIGH:    lim_x_hi = data;
      tdhb_pkg::CFG_Y_LOW:     lim_y_lo = data;
      tdhb_pkg::CFG_Y_HIGH:    lim_y_hi = data;
      tdhb_pkg::CFG_THRESHOLD: thresh_ppm = data[tdhb_pkg::PPM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(logic signed [tdhb_pkg::COORD_W-1:0] xl, xh, yl, yh, int ppm,
                           int idle_pct, int n_items, int drain_at);
    wait_drained();
    write_reg(tdhb_pkg::CFG_X_LOW, xl);
    write_reg(tdhb_pkg::CFG_X_HIGH, xh);
    write_reg(tdhb_pkg::CFG_Y_LOW, yl);
    write_reg(tdhb_pkg::CFG_Y_HIGH, yh);
    write_reg(tdhb_pkg::CFG_THRESHOLD, 32'(ppm));
    cfg_valid <= 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i == drain_at) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        idle_before_item(idle_pct);
      end
      send_item(random_request(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    tdhb_pkg::res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (result.accepted !== want.accepted)
          report_mismatch($sformatf("accepted got %0b want %0b",
                                    result.accepted, want.accepted));
        if (result.bin_row !== want.bin_row)
          report_mismatch($sformatf("bin_row got %0d want %0d", result.bin_row, want.bin_row));
        if (result.bin_col !== want.bin_col)
          report_mismatch($sformatf("bin_col got %0d want %0d", result.bin_col, want.bin_col));
        if (result.cell_count !== want.cell_count)
          report_mismatch($sformatf("cell_count got %0d want %0d",
                                    result.cell_count, want.cell_count));
        if (result.total_count !== want.total_count)
          report_mismatch($sformatf("total_count got %0d want %0d",
                                    result.total_count, want.total_count));
        if (result.above_threshold !== want.above_threshold)
          report_mismatch($sformatf("above_threshold got %0b want %0b",
                                    result.above_threshold, want.above_threshold));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [tdhb_pkg::COORD_W-1:0] ra, rb, rt;
    foreach (hist[i]) hist[i] = '0;

    // Rows with a typed result are checked against that value; others use the predictor.
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd0, 8'd0, 1,
            '{1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0});
    dir_row(tdhb_pkg::OP_ADD, tdhb_pkg::X_LOW_RESET, tdhb_pkg::Y_LOW_RESET, 8'd0, 8'd0, 1,
            '{1'b1, 8'd0, 8'd0, 32'd1, 32'd1, 1'b1});
    dir_row(tdhb_pkg::OP_ADD, tdhb_pkg::X_HIGH_RESET, tdhb_pkg::Y_HIGH_RESET, 8'd0, 8'd0, 1,
            '{1'b1, 8'd99, 8'd99, 32'd1, 32'd2, 1'b1});
    dir_row(tdhb_pkg::OP_ADD, tdhb_pkg::X_LOW_RESET - 1, tdhb_pkg::Y_LOW_RESET, 8'd0, 8'd0, 1,
            '{1'b0, 8'd0, 8'd0, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_ADD, tdhb_pkg::X_LOW_RESET, -32'sd1, 8'd0, 8'd0, 1,
            '{1'b0, 8'd0, 8'd0, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_ADD, tdhb_pkg::X_HIGH_RESET + 1, tdhb_pkg::Y_LOW_RESET, 8'd0, 8'd0, 1,
            '{1'b0, 8'd0, 8'd0, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'd0, 8'd0, 1,
            '{1'b0, 8'd0, 8'd0, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'd255, 8'd255, 1,
            '{1'b0, 8'd0, 8'd0, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_READ, -32'sd1, -32'sd1, 8'd255, 8'd255, 1,
            '{1'b0, 8'd255, 8'd255, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd100, 8'd0, 1,
            '{1'b0, 8'd100, 8'd0, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd0, 8'd100, 1,
            '{1'b0, 8'd0, 8'd100, 32'd0, 32'd2, 1'b0});
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd99, 8'd99, 1,
            '{1'b0, 8'd99, 8'd99, 32'd1, 32'd2, 1'b1});
    dir_row(tdhb_pkg::OP_ADD, 32'sd4587520, 32'sd26214, 8'd0, 8'd0, 0, '0);
    dir_row(tdhb_pkg::OP_ADD, 32'sd4587520, 32'sd26214, 8'd0, 8'd0, 0, '0);
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd50, 8'd49, 0, '0);
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd0, 8'd0, 0, '0);
    dir_row(tdhb_pkg::OP_ADD, tdhb_pkg::X_HIGH_RESET - 1, tdhb_pkg::Y_HIGH_RESET - 1,
            8'd0, 8'd0, 0, '0);
    dir_row(tdhb_pkg::OP_READ, 0, 0, 8'd98, 8'd98, 0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i].rq, directed_rows[i].typed,
                                         directed_rows[i].want);

    run_phase(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
              0, 90, -1);
    run_phase(-32'sd5, 32'sd5, 32'sd10, 32'sd10, 1000000, 86, 80, -1);
    run_phase(32'sd0, 32'sd3, -32'sd7, -32'sd3, 30000, 6, 100, 50);
    run_phase(32'sd100, 32'sd50, 32'sd0, 32'sd1000, 500, 0, 30, -1);
    run_phase(32'sd7, 32'sd7, 32'sh8000_0000, 32'sd100, 250000, 86, 80, -1);
    ra = $urandom();
    rb = $urandom();
    if (ra > rb) begin
      rt = ra;
      ra = rb;
      rb = rt;
    end
    run_phase(ra, rb, -32'sd65536, 32'sd65536, $urandom_range(0, 1000000), 6, 100, -1);

    wait_drained();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tdhb_pkg.sv
rtl/tdhb_ram.sv
rtl/tdhb_divider.sv
rtl/two_d_histogram_binner.sv
bench/two_d_histogram_binner_tb.sv
